// File: src/pscc_pkg.sv
// Shared types, constants and arithmetic helpers for the coordinate converter.
// Holds the CORDIC arctangent table, the rotator state type and the rounding function.
// No dependencies; every other file in src imports this package.
package pscc_pkg;

   localparam int FRAC  = 30;
   localparam int STEPS = 30;

   // Rotator gain correction, 0.60725... in Q1.30.
   localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

   // Arctangent of 2^-i as a fraction of a full turn scaled by 2^32.
   localparam logic signed [31:0] ATAN_TABLE [STEPS] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
      32'sd21354465,  32'sd10679838,  32'sd5340245,   32'sd2670163,  32'sd1335087,
      32'sd667544,    32'sd333772,    32'sd166886,    32'sd83443,    32'sd41721,
      32'sd20861,     32'sd10430,     32'sd5215,      32'sd2608,     32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81,       32'sd41,
      32'sd20,        32'sd10,        32'sd5,         32'sd3,        32'sd1
   };

   typedef enum logic [1:0] {
      QUAD_0   = 2'd0,
      QUAD_90  = 2'd1,
      QUAD_180 = 2'd2,
      QUAD_270 = 2'd3
   } quad_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      quad_type           quad;
   } rot_type;

   typedef struct packed {
      logic signed [31:0] c;
      logic signed [31:0] s;
   } trig_type;

   // Splits a 32-bit binary angle into the nearest quarter turn and a residual
   // within one eighth of a turn, and loads the rotator start vector.
   function automatic rot_type rot_prep(input logic [31:0] a32);
      logic [31:0] biased;
      rot_type     r;
      biased = a32 + 32'h2000_0000;
      r.quad = quad_type'(biased[31:30]);
      r.x    = CORDIC_GAIN;
      r.y    = '0;
      r.z    = $signed(a32 - {biased[31:30], 30'd0});
      return r;
   endfunction

   // One micro-rotation; shifts are arithmetic, so they round toward minus infinity.
   function automatic rot_type rot_step(input rot_type a, input int shift,
                                        input logic signed [31:0] atan);
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      rot_type            r;
      dx     = a.y >>> shift;
      dy     = a.x >>> shift;
      r.quad = a.quad;
      if (!a.z[31]) begin
         r.x = a.x - dx;
         r.y = a.y + dy;
         r.z = a.z - atan;
      end else begin
         r.x = a.x + dx;
         r.y = a.y - dy;
         r.z = a.z + atan;
      end
      return r;
   endfunction

   // Rotates the first-quadrant result back into the angle's own quadrant.
   function automatic trig_type quad_map(input rot_type a);
      trig_type t;
      case (a.quad)
         QUAD_0: begin
            t.c = a.x;
            t.s = a.y;
         end
         QUAD_90: begin
            t.c = -a.y;
            t.s = a.x;
         end
         QUAD_180: begin
            t.c = -a.x;
            t.s = -a.y;
         end
         QUAD_270: begin
            t.c = a.y;
            t.s = -a.x;
         end
         default: begin
            t.c = a.x;
            t.s = a.y;
         end
      endcase
      return t;
   endfunction

   // Drops the 30 fraction bits, rounding to nearest with ties away from zero.
   function automatic logic signed [33:0] round_q30(input logic signed [63:0] p);
      logic [63:0]        mag;
      logic [63:0]        q;
      logic signed [33:0] r;
      mag = p[63] ? 64'(-p) : 64'(p);
      q   = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
      r   = $signed(q[33:0]);
      return p[63] ? -r : r;
   endfunction

endpackage

// File: src/pscc_cordic_cell.sv
// One CORDIC micro-rotation stage for the azimuth and polar rotators.
// Carries the point's other fields alongside; a valid bit and a ready that
// ripples back let the row close bubbles. Depends on pscc_pkg.
module pscc_cordic_cell #(
   parameter int DATA_BITS = 16,
   parameter int STEP      = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  pscc_pkg::rot_type             up_az,
   input  pscc_pkg::rot_type             up_pol,
   input  logic                          up_kind,
   input  logic signed [DATA_BITS-1:0]   up_radius,
   input  logic signed [DATA_BITS-1:0]   up_height,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output pscc_pkg::rot_type             dn_az,
   output pscc_pkg::rot_type             dn_pol,
   output logic                          dn_kind,
   output logic signed [DATA_BITS-1:0]   dn_radius,
   output logic signed [DATA_BITS-1:0]   dn_height
);
   import pscc_pkg::*;

   logic                        valid_ff;
   rot_type                     az_ff;
   rot_type                     az_in;
   rot_type                     pol_ff;
   rot_type                     pol_in;
   logic                        kind_ff;
   logic signed [DATA_BITS-1:0] radius_ff;
   logic signed [DATA_BITS-1:0] height_ff;

   // The stage can take a beat when it is empty or its contents move on.
   assign up_ready = !valid_ff || dn_ready;

   assign az_in  = rot_step(up_az, STEP, ATAN_TABLE[STEP]);
   assign pol_in = rot_step(up_pol, STEP, ATAN_TABLE[STEP]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         az_ff     <= az_in;
         pol_ff    <= pol_in;
         kind_ff   <= up_kind;
         radius_ff <= up_radius;
         height_ff <= up_height;
      end
   end

   assign dn_valid  = valid_ff;
   assign dn_az     = az_ff;
   assign dn_pol    = pol_ff;
   assign dn_kind   = kind_ff;
   assign dn_radius = radius_ff;
   assign dn_height = height_ff;

endmodule

// File: src/pscc_scale.sv
// Output pipeline: quadrant correction, sine products, radius scaling,
// rounding and saturation, in four registered stages with bubble-closing
// flow control. Depends on pscc_pkg.
module pscc_scale #(
   parameter int DATA_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  pscc_pkg::rot_type             up_az,
   input  pscc_pkg::rot_type             up_pol,
   input  logic                          up_kind,
   input  logic signed [DATA_BITS-1:0]   up_radius,
   input  logic signed [DATA_BITS-1:0]   up_height,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output logic signed [DATA_BITS-1:0]   dn_x,
   output logic signed [DATA_BITS-1:0]   dn_y,
   output logic signed [DATA_BITS-1:0]   dn_z,
   output logic                          dn_saturated
);
   import pscc_pkg::*;

   localparam int NUM_STAGES = 4;
   localparam int PW         = DATA_BITS + 32;
   localparam logic signed [33:0] MAX_V = 34'((64'sd1 <<< (DATA_BITS - 1)) - 64'sd1);
   localparam logic signed [33:0] MIN_V = -MAX_V - 34'sd1;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] adv;

   // Stage 1 signals.
   trig_type                    az_t;
   trig_type                    pol_t;
   logic signed [63:0]          s1_px_in;
   logic signed [63:0]          s1_py_in;
   logic signed [63:0]          s1_px_ff;
   logic signed [63:0]          s1_py_ff;
   logic signed [31:0]          s1_ca_ff;
   logic signed [31:0]          s1_sa_ff;
   logic signed [31:0]          s1_cp_ff;
   logic                        s1_kind_ff;
   logic signed [DATA_BITS-1:0] s1_radius_ff;
   logic signed [DATA_BITS-1:0] s1_height_ff;

   // Stage 2 signals.
   logic signed [33:0]          rnd_px;
   logic signed [33:0]          rnd_py;
   logic signed [31:0]          s2_fx_in;
   logic signed [31:0]          s2_fy_in;
   logic signed [31:0]          s2_fx_ff;
   logic signed [31:0]          s2_fy_ff;
   logic signed [31:0]          s2_fz_ff;
   logic                        s2_kind_ff;
   logic signed [DATA_BITS-1:0] s2_radius_ff;
   logic signed [DATA_BITS-1:0] s2_height_ff;

   // Stage 3 signals.
   logic signed [PW-1:0]        s3_mx_in;
   logic signed [PW-1:0]        s3_my_in;
   logic signed [PW-1:0]        s3_mz_in;
   logic signed [PW-1:0]        s3_mx_ff;
   logic signed [PW-1:0]        s3_my_ff;
   logic signed [PW-1:0]        s3_mz_ff;
   logic                        s3_kind_ff;
   logic signed [DATA_BITS-1:0] s3_height_ff;

   // Stage 4 signals.
   logic signed [33:0]          rx;
   logic signed [33:0]          ry;
   logic signed [33:0]          rz;
   logic signed [DATA_BITS-1:0] x_in;
   logic signed [DATA_BITS-1:0] y_in;
   logic signed [DATA_BITS-1:0] z_in;
   logic                        sat_in;
   logic                        sat_x;
   logic                        sat_y;
   logic                        sat_z;
   logic signed [DATA_BITS-1:0] x_ff;
   logic signed [DATA_BITS-1:0] y_ff;
   logic signed [DATA_BITS-1:0] z_ff;
   logic                        sat_ff;

   // A stage moves when it is empty or the stage after it moves.
   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || dn_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign up_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= up_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // Stage 1: sine of polar times cosine and sine of azimuth.
   assign az_t     = quad_map(up_az);
   assign pol_t    = quad_map(up_pol);
   assign s1_px_in = pol_t.s * az_t.c;
   assign s1_py_in = pol_t.s * az_t.s;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_px_ff     <= s1_px_in;
         s1_py_ff     <= s1_py_in;
         s1_ca_ff     <= az_t.c;
         s1_sa_ff     <= az_t.s;
         s1_cp_ff     <= pol_t.c;
         s1_kind_ff   <= up_kind;
         s1_radius_ff <= up_radius;
         s1_height_ff <= up_height;
      end
   end

   // Stage 2: pick the factor that the radius multiplies.
   assign rnd_px   = round_q30(s1_px_ff);
   assign rnd_py   = round_q30(s1_py_ff);
   assign s2_fx_in = s1_kind_ff ? rnd_px[31:0] : s1_ca_ff;
   assign s2_fy_in = s1_kind_ff ? rnd_py[31:0] : s1_sa_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_fx_ff     <= s2_fx_in;
         s2_fy_ff     <= s2_fy_in;
         s2_fz_ff     <= s1_cp_ff;
         s2_kind_ff   <= s1_kind_ff;
         s2_radius_ff <= s1_radius_ff;
         s2_height_ff <= s1_height_ff;
      end
   end

   // Stage 3: radius scaling.
   assign s3_mx_in = s2_radius_ff * s2_fx_ff;
   assign s3_my_in = s2_radius_ff * s2_fy_ff;
   assign s3_mz_in = s2_radius_ff * s2_fz_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_mx_ff     <= s3_mx_in;
         s3_my_ff     <= s3_my_in;
         s3_mz_ff     <= s3_mz_in;
         s3_kind_ff   <= s2_kind_ff;
         s3_height_ff <= s2_height_ff;
      end
   end

   // Stage 4: round, clip to the data width and flag any clipping.
   assign rx = round_q30(64'(s3_mx_ff));
   assign ry = round_q30(64'(s3_my_ff));
   assign rz = round_q30(64'(s3_mz_ff));

   always_comb begin
      sat_x = (rx > MAX_V) || (rx < MIN_V);
      sat_y = (ry > MAX_V) || (ry < MIN_V);
      sat_z = s3_kind_ff && ((rz > MAX_V) || (rz < MIN_V));
      if (rx > MAX_V) begin
         x_in = MAX_V[DATA_BITS-1:0];
      end else if (rx < MIN_V) begin
         x_in = MIN_V[DATA_BITS-1:0];
      end else begin
         x_in = rx[DATA_BITS-1:0];
      end
      if (ry > MAX_V) begin
         y_in = MAX_V[DATA_BITS-1:0];
      end else if (ry < MIN_V) begin
         y_in = MIN_V[DATA_BITS-1:0];
      end else begin
         y_in = ry[DATA_BITS-1:0];
      end
      // The cylindrical height passes through untouched.
      if (!s3_kind_ff) begin
         z_in = s3_height_ff;
      end else if (rz > MAX_V) begin
         z_in = MAX_V[DATA_BITS-1:0];
      end else if (rz < MIN_V) begin
         z_in = MIN_V[DATA_BITS-1:0];
      end else begin
         z_in = rz[DATA_BITS-1:0];
      end
      sat_in = sat_x || sat_y || sat_z;
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         sat_ff <= sat_in;
      end
   end

   assign dn_valid     = valid_ff[NUM_STAGES-1];
   assign dn_x         = x_ff;
   assign dn_y         = y_ff;
   assign dn_z         = z_ff;
   assign dn_saturated = sat_ff;

endmodule

// File: src/polar_spherical_to_cartesian_top.sv
// Spherical and cylindrical to Cartesian converter, top level.
// Request channel (req_valid/req_ready) takes one point per beat: req_kind selects
// cylindrical (0) or spherical (1), radius and height are signed fixed point,
// azimuth and polar angle are binary angles where 2^ANGLE_BITS is one full turn.
// Response channel (rsp_valid/rsp_ready) returns one beat per point, in order:
// x, y, z rounded to nearest and clipped to the data width, and a saturated flag.
// Pipeline from request beat to response valid: 30 CORDIC cells,
// each doing one micro-rotation for both angles, then four scaling stages
// (quadrant fix and sine products, factor select, radius multiply, round and clip).
// Throughput is one point per clock while the receiver keeps rsp_ready high; every stage holds a beat of its own.
// When the receiver stalls, beats keep moving into empty stages until the row is
// full; ready ripples back from the response side, so gaps close up.
// Synchronous reset empties every stage; nothing else needs initializing.
// Depends on pscc_pkg, pscc_cordic_cell and pscc_scale.
module polar_spherical_to_cartesian_top #(
   parameter int DATA_BITS  = 16,
   parameter int ANGLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic signed [DATA_BITS-1:0]   req_radius,
   input  logic [ANGLE_BITS-1:0]         req_azimuth,
   input  logic [ANGLE_BITS-1:0]         req_polar_angle,
   input  logic signed [DATA_BITS-1:0]   req_height,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [DATA_BITS-1:0]   rsp_x_out,
   output logic signed [DATA_BITS-1:0]   rsp_y_out,
   output logic signed [DATA_BITS-1:0]   rsp_z_out,
   output logic                          rsp_saturated
);
   import pscc_pkg::*;

   logic [31:0]                 az32;
   logic [31:0]                 pol32;

   logic                        valid_chain  [STEPS+1];
   logic                        ready_chain  [STEPS+1];
   rot_type                     az_chain     [STEPS+1];
   rot_type                     pol_chain    [STEPS+1];
   logic                        kind_chain   [STEPS+1];
   logic signed [DATA_BITS-1:0] radius_chain [STEPS+1];
   logic signed [DATA_BITS-1:0] height_chain [STEPS+1];

   // Widen the angles so one turn is 2^32.
   assign az32  = 32'(req_azimuth) << (32 - ANGLE_BITS);
   assign pol32 = 32'(req_polar_angle) << (32 - ANGLE_BITS);

   assign valid_chain[0]  = req_valid;
   assign req_ready       = ready_chain[0];
   assign az_chain[0]     = rot_prep(az32);
   assign pol_chain[0]    = rot_prep(pol32);
   assign kind_chain[0]   = req_kind;
   assign radius_chain[0] = req_radius;
   assign height_chain[0] = req_height;

   for (genvar g = 0; g < STEPS; g++) begin : g_cell
      pscc_cordic_cell #(
         .DATA_BITS (DATA_BITS),
         .STEP      (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_valid  (valid_chain[g]),
         .up_ready  (ready_chain[g]),
         .up_az     (az_chain[g]),
         .up_pol    (pol_chain[g]),
         .up_kind   (kind_chain[g]),
         .up_radius (radius_chain[g]),
         .up_height (height_chain[g]),
         .dn_valid  (valid_chain[g+1]),
         .dn_ready  (ready_chain[g+1]),
         .dn_az     (az_chain[g+1]),
         .dn_pol    (pol_chain[g+1]),
         .dn_kind   (kind_chain[g+1]),
         .dn_radius (radius_chain[g+1]),
         .dn_height (height_chain[g+1])
      );
   end

   pscc_scale #(
      .DATA_BITS (DATA_BITS)
   ) u_scale (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (valid_chain[STEPS]),
      .up_ready     (ready_chain[STEPS]),
      .up_az        (az_chain[STEPS]),
      .up_pol       (pol_chain[STEPS]),
      .up_kind      (kind_chain[STEPS]),
      .up_radius    (radius_chain[STEPS]),
      .up_height    (height_chain[STEPS]),
      .dn_valid     (rsp_valid),
      .dn_ready     (rsp_ready),
      .dn_x         (rsp_x_out),
      .dn_y         (rsp_y_out),
      .dn_z         (rsp_z_out),
      .dn_saturated (rsp_saturated)
   );

endmodule

// File: tb/tb_polar_spherical_to_cartesian_top.sv
// Testbench for the spherical and cylindrical to Cartesian converter.
// A scoreboard class predicts x, y, z and the clip flag for every accepted point.
// Depends on pscc_pkg (quadrant codes) and polar_spherical_to_cartesian_top.
`timescale 1ns / 1ps

module tb_polar_spherical_to_cartesian_top;

   localparam int DATA_W = 16;
   localparam int ANG_W  = 16;
   localparam int ROT_STEPS = 30;
   localparam longint ROT_GAIN = 652032874;
   localparam int DRAIN_CYCLES = 40;

   // Arctangent of 2^-i in units of 2^-32 turn.
   localparam longint ATAN_TURN [ROT_STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41721, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1
   };

   typedef enum logic {
      KIND_CYL = 1'b0,
      KIND_SPH = 1'b1
   } kind_type;

   typedef struct {
      kind_type                  kind;
      logic signed [DATA_W-1:0]  radius;
      logic [ANG_W-1:0]          azimuth;
      logic [ANG_W-1:0]          polar_angle;
      logic signed [DATA_W-1:0]  height;
   } point_type;

   typedef struct {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
      logic                     sat;
   } cart_type;

   class cart_scoreboard;
      cart_type cart_pending[$];
      int       n_checked;
      int       n_errors;
      int       n_spherical;
      int       n_clipped;

      // Cosine and sine in Q1.30 from a rotation-mode CORDIC on the residual angle.
      function void trig_q30(input logic [ANG_W-1:0] ang, output longint c,
                             output longint s);
         int unsigned a32;
         int unsigned quad;
         int unsigned resid;
         longint      x;
         longint      y;
         longint      z;
         longint      dx;
         longint      dy;
         a32   = {ang, {(32-ANG_W){1'b0}}};
         quad  = (a32 + 32'h2000_0000) >> 30;
         resid = a32 - (quad << 30);
         z     = longint'($signed(resid));
         x     = ROT_GAIN;
         y     = 0;
         for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - ATAN_TURN[i];
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + ATAN_TURN[i];
            end
         end
         case (pscc_pkg::quad_type'(quad[1:0]))
            pscc_pkg::QUAD_0: begin
               c = x;
               s = y;
            end
            pscc_pkg::QUAD_90: begin
               c = -y;
               s = x;
            end
            pscc_pkg::QUAD_180: begin
               c = -x;
               s = -y;
            end
            default: begin
               c = y;
               s = -x;
            end
         endcase
      endfunction

      // Drops 30 fraction bits, rounding half away from zero.
      function longint round_q30(longint p);
         longint mag;
         mag = (p < 0) ? -p : p;
         mag = (mag + (longint'(1) << 29)) >>> 30;
         return (p < 0) ? -mag : mag;
      endfunction

      function logic signed [DATA_W-1:0] clip(longint v, inout bit hit);
         longint hi;
         longint lo;
         hi = (longint'(1) << (DATA_W - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) begin
            hit = 1'b1;
            v = hi;
         end else if (v < lo) begin
            hit = 1'b1;
            v = lo;
         end
         return v[DATA_W-1:0];
      endfunction

      function cart_type to_cartesian(point_type p);
         longint   r;
         longint   ca;
         longint   sa;
         longint   cp;
         longint   sp;
         longint   x;
         longint   y;
         longint   z;
         bit       hit;
         cart_type res;
         hit = 1'b0;
         r   = p.radius;
         trig_q30(p.azimuth, ca, sa);
         if (p.kind == KIND_SPH) begin
            trig_q30(p.polar_angle, cp, sp);
            x = round_q30(r * round_q30(sp * ca));
            y = round_q30(r * round_q30(sp * sa));
            z = round_q30(r * cp);
         end else begin
            x = round_q30(r * ca);
            y = round_q30(r * sa);
            z = p.height;
         end
         res.x   = clip(x, hit);
         res.y   = clip(y, hit);
         res.z   = clip(z, hit);
         res.sat = hit;
         return res;
      endfunction

      function void note(point_type p);
         cart_pending.push_back(to_cartesian(p));
         if (p.kind == KIND_SPH) n_spherical++;
      endfunction

      function void compare_field(string name, logic signed [DATA_W-1:0] want,
                                  logic signed [DATA_W-1:0] got);
         if (got !== want) begin
            n_errors++;
            $error("%s: expected %0d, actual %0d", name, want, got);
         end
      endfunction

      function void check(logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] y,
                          logic signed [DATA_W-1:0] z, logic sat);
         cart_type want;
         if (cart_pending.size() == 0) begin
            n_errors++;
            $error("result beat arrived with no point pending");
            return;
         end
         want = cart_pending.pop_front();
         n_checked++;
         if (want.sat) n_clipped++;
         compare_field("x_out", want.x, x);
         compare_field("y_out", want.y, y);
         compare_field("z_out", want.z, z);
         compare_field("saturated", want.sat, sat);
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_kind = 1'b0;
   logic signed [DATA_W-1:0] req_radius = '0;
   logic [ANG_W-1:0]         req_azimuth = '0;
   logic [ANG_W-1:0]         req_polar_angle = '0;
   logic signed [DATA_W-1:0] req_height = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_x_out;
   logic signed [DATA_W-1:0] rsp_y_out;
   logic signed [DATA_W-1:0] rsp_z_out;
   logic                     rsp_saturated;

   cart_scoreboard sb;
   int send_idle_pct = 6;
   int recv_idle_pct = 6;
   int hold_cycles = 0;
   int n_input_stalls = 0;

   polar_spherical_to_cartesian_top #(
      .DATA_BITS  (DATA_W),
      .ANGLE_BITS (ANG_W)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_radius      (req_radius),
      .req_azimuth     (req_azimuth),
      .req_polar_angle (req_polar_angle),
      .req_height      (req_height),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_x_out       (rsp_x_out),
      .rsp_y_out       (rsp_y_out),
      .rsp_z_out       (rsp_z_out),
      .rsp_saturated   (rsp_saturated)
   );

   always #1 clock = ~clock;

   function automatic point_type make_point(kind_type k, int r, int az, int pol, int h);
      point_type p;
      p.kind        = k;
      p.radius      = r[DATA_W-1:0];
      p.azimuth     = az[ANG_W-1:0];
      p.polar_angle = pol[ANG_W-1:0];
      p.height      = h[DATA_W-1:0];
      return p;
   endfunction

   // Fully random fields, with extra weight on extreme radii and on angles
   // close to the quadrant and octant boundaries.
   function automatic point_type random_point();
      point_type   p;
      int unsigned pick;
      p.kind        = kind_type'($urandom_range(1));
      p.radius      = DATA_W'($urandom);
      p.azimuth     = ANG_W'($urandom);
      p.polar_angle = ANG_W'($urandom);
      p.height      = DATA_W'($urandom);
      pick = $urandom_range(9);
      if (pick < 2) begin
         p.radius = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      end else if (pick < 4) begin
         p.radius = DATA_W'(int'($urandom_range(512)) - 256);
      end
      if ($urandom_range(3) == 0)
         p.azimuth = ANG_W'(($urandom_range(7) << 13) + $urandom_range(4) - 2);
      if ($urandom_range(3) == 0)
         p.polar_angle = ANG_W'(($urandom_range(7) << 13) + $urandom_range(4) - 2);
      return p;
   endfunction

   task automatic send_point(point_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= p.kind;
      req_radius      <= p.radius;
      req_azimuth     <= p.azimuth;
      req_polar_angle <= p.polar_angle;
      req_height      <= p.height;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note(p);
   endtask

   task automatic send_random(int count);
      for (int i = 0; i < count; i++) send_point(random_point());
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      wait (!reset);
      forever begin
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check(rsp_x_out, rsp_y_out, rsp_z_out, rsp_saturated);
      if (!reset && req_valid && !req_ready) n_input_stalls++;
   end

   initial begin
      #400_000;
      $display("Run timed out with %0d results outstanding.", sb.cart_pending.size());
      $display("status: fail");
      $finish;
   end

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: axis angles, octant edges, clipping at -32768, ignored fields.
      send_point(make_point(KIND_CYL, 0, 'h0000, 'h0000, 0));
      send_point(make_point(KIND_CYL, 32767, 'h0000, 'h0000, 32767));
      send_point(make_point(KIND_CYL, 32767, 'h4000, 'h1234, -32768));
      send_point(make_point(KIND_CYL, -32768, 'h8000, 'h0000, 0));
      send_point(make_point(KIND_CYL, -32768, 'hC000, 'h0000, 0));
      send_point(make_point(KIND_CYL, -32768, 'h2000, 'h0000, 100));
      send_point(make_point(KIND_CYL, 32767, 'h1FFF, 'hFFFF, -1));
      send_point(make_point(KIND_CYL, 1, 'hFFFF, 'h0000, 1));
      send_point(make_point(KIND_CYL, -1, 'h6000, 'h0000, 0));
      send_point(make_point(KIND_CYL, 256, 'h8001, 'h0000, 0));
      send_point(make_point(KIND_SPH, 32767, 'h0000, 'h0000, 32767));
      send_point(make_point(KIND_SPH, 32767, 'h4000, 'h4000, 0));
      send_point(make_point(KIND_SPH, -32768, 'h0000, 'h8000, 0));
      send_point(make_point(KIND_SPH, -32768, 'h8000, 'h4000, 0));
      send_point(make_point(KIND_SPH, -32768, 'h4000, 'hC000, 0));
      send_point(make_point(KIND_SPH, 32767, 'h6000, 'hE000, -32768));
      send_point(make_point(KIND_SPH, 0, 'hFFFF, 'hFFFF, 0));
      send_point(make_point(KIND_SPH, 1, 'h2000, 'h2000, 0));
      send_point(make_point(KIND_SPH, -1, 'hA000, 'h1FFF, 5));
      send_point(make_point(KIND_SPH, 256, 'h0001, 'h7FFF, 0));

      send_random(450);

      // Back-to-back beats on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(250);

      // The receiver holds off long enough for the pipeline to fill and stall input.
      send_idle_pct = 6;
      recv_idle_pct = 6;
      hold_cycles   = 150;
      send_random(480);

      req_valid <= 1'b0;
      while (sb.cart_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d result beats: %0d spherical points, %0d clipped results.",
               sb.n_checked, sb.n_spherical, sb.n_clipped);
      $display("Input was held off for %0d cycles by output back-pressure.",
               n_input_stalls);
      if (sb.n_errors == 0 && sb.cart_pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
